>>> rtl/enter_exit_latency_profiler_macros.svh
// ----------------------------------------------------------------------------
// enter/exit latency profiler assertion macros
// shared concurrent assertion helpers, clocked on clk_i, reset rst_ni
// ----------------------------------------------------------------------------
`ifndef ENTER_EXIT_LATENCY_PROFILER_MACROS_SVH
`define ENTER_EXIT_LATENCY_PROFILER_MACROS_SVH

`ifndef ASSERT_OFF
`define EELP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("eelp assertion failed");
`define EELP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("eelp assertion failed");
`else
`define EELP_ASSERT(lbl, prop)
`define EELP_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

>>> rtl/eelp_pkg.sv
// ----------------------------------------------------------------------------
// eelp_pkg
// types, constants and helpers of the enter/exit latency profiler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eelp_pkg;

  localparam int unsigned NumOpsDefault   = 7;
  localparam int unsigned NestBitsDefault = 8;

  localparam logic [26:0] DayMs  = 27'd86400000;
  localparam logic [26:0] HourMs = 27'd3600000;
  localparam logic [26:0] MinMs  = 27'd60000;
  localparam logic [26:0] SecMs  = 27'd1000;
  localparam logic [26:0] MinRst = 27'd99999;

  // request types on the input
  localparam logic [2:0] REQ_HEADER = 3'd1;
  localparam logic [2:0] REQ_ENTER  = 3'd2;
  localparam logic [2:0] REQ_EXIT   = 3'd3;
  localparam logic [2:0] REQ_NOEE   = 3'd4;

  // result item kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_SPAN   = 2'd2;

  // status codes
  localparam logic [3:0] STS_ENTER    = 4'd0;
  localparam logic [3:0] STS_EXIT     = 4'd1;
  localparam logic [3:0] STS_NESTED   = 4'd2;
  localparam logic [3:0] STS_HEADER   = 4'd3;
  localparam logic [3:0] STS_TIMED    = 4'd4;
  localparam logic [3:0] STS_NO_ENTER = 4'd5;
  localparam logic [3:0] STS_UNDERRUN = 4'd6;
  localparam logic [3:0] STS_NOEE     = 4'd7;
  localparam logic [3:0] STS_FLUSHED  = 4'd8;

  typedef enum logic [2:0] {
    CMD_TIMED  = 3'd0,
    CMD_HEADER = 3'd1,
    CMD_ENTER  = 3'd2,
    CMD_EXIT   = 3'd3,
    CMD_NOEE   = 3'd4,
    CMD_FLUSH  = 3'd5
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [2:0]  op;
    logic [26:0] t;
  } cmd_t;

  typedef struct packed {
    logic        last;
    logic [15:0] rep;
    logic [26:0] min;
    logic [26:0] max;
    logic [31:0] cnt;
    logic [31:0] tot;
    logic [26:0] dur;
    logic [2:0]  op;
    logic [3:0]  status;
    logic [1:0]  kind;
  } item_t;

  // time from one stamp to another, over midnight by one day
  function automatic logic [26:0] elapsed(input logic [26:0] from, input logic [26:0] to);
    logic [27:0] w;
    if (to < from) begin
      w = 28'(to) + 28'(DayMs) - 28'(from);
    end else begin
      w = 28'(to) - 28'(from);
    end
    return w[26:0];
  endfunction

endpackage

>>> rtl/eelp_front.sv
// ----------------------------------------------------------------------------
// eelp_front
// accepts events, classifies them and folds the timestamp into milliseconds
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eelp_front #(
  parameter int unsigned NUM_OPS = eelp_pkg::NumOpsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [2:0]    req_type_i,
  input  logic [2:0]    op_id_i,
  input  logic          flush_req_i,
  input  logic [4:0]    hours_i,
  input  logic [5:0]    minutes_i,
  input  logic [5:0]    seconds_i,
  input  logic [9:0]    millis_i,
  output logic          push_o,
  output eelp_pkg::cmd_t cmd_o,
  input  logic          full_i
);
  import eelp_pkg::*;

  logic      f_vld_q, f_vld_d;
  cmd_t      f_cmd_q, f_cmd_d;
  cmd_kind_e kind;
  logic      op_ok;
  logic [26:0] raw;

  assign op_ok = 5'(op_id_i) < 5'(NUM_OPS);

  always_comb begin
    if (flush_req_i) begin
      kind = CMD_FLUSH;
    end else if (req_type_i == REQ_HEADER) begin
      kind = CMD_HEADER;
    end else if (op_ok && req_type_i == REQ_ENTER) begin
      kind = CMD_ENTER;
    end else if (op_ok && req_type_i == REQ_EXIT) begin
      kind = CMD_EXIT;
    end else if (op_ok && req_type_i == REQ_NOEE) begin
      kind = CMD_NOEE;
    end else begin
      kind = CMD_TIMED;
    end
  end

  // largest raw sum stays below two days, one subtract folds it
  assign raw = 27'(hours_i) * HourMs + 27'(minutes_i) * MinMs
             + 27'(seconds_i) * SecMs + 27'(millis_i);

  assign push_o     = f_vld_q && !full_i;
  assign in_ready_o = !f_vld_q || !full_i;

  always_comb begin
    cmd_o = f_cmd_q;
    if (f_cmd_q.t >= DayMs) begin
      cmd_o.t = f_cmd_q.t - DayMs;
    end
  end

  always_comb begin
    f_vld_d = f_vld_q;
    f_cmd_d = f_cmd_q;
    if (push_o) begin
      f_vld_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      f_vld_d      = 1'b1;
      f_cmd_d.kind = kind;
      f_cmd_d.op   = op_id_i;
      f_cmd_d.t    = raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= f_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_cmd_q <= f_cmd_d;
  end

endmodule

>>> rtl/eelp_fifo.sv
// ----------------------------------------------------------------------------
// eelp_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "enter_exit_latency_profiler_macros.svh"

module eelp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  eelp_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output eelp_pkg::cmd_t data_o
);
  import eelp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = !wr_q;
    end
    if (pop_i) begin
      rd_d = !rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `EELP_ASSERT(a_cnt_bound, cnt_q != 2'd3)
  `EELP_ASSERT_IMP(a_ptr_gap, cnt_q == 2'd0 || cnt_q == 2'd2, wr_q == rd_q)

endmodule

>>> rtl/eelp_back.sv
// ----------------------------------------------------------------------------
// eelp_back
// per-operation latency table, nesting, span and report sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "enter_exit_latency_profiler_macros.svh"

module eelp_back #(
  parameter int unsigned NUM_OPS   = eelp_pkg::NumOpsDefault,
  parameter int unsigned NEST_BITS = eelp_pkg::NestBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  eelp_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output eelp_pkg::item_t out_o
);
  import eelp_pkg::*;

  localparam int unsigned IdxW = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_UPD  = 6'b000100,
    ST_REP  = 6'b001000,
    ST_SPAN = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [26:0] dur_q, dur_d;

  logic [26:0] st_time_q [NUM_OPS];
  logic [26:0] st_time_d [NUM_OPS];
  logic        st_vld_q  [NUM_OPS];
  logic        st_vld_d  [NUM_OPS];
  logic [31:0] tot_q     [NUM_OPS];
  logic [31:0] tot_d     [NUM_OPS];
  logic [31:0] cnt_q     [NUM_OPS];
  logic [31:0] cnt_d     [NUM_OPS];
  logic [26:0] max_q     [NUM_OPS];
  logic [26:0] max_d     [NUM_OPS];
  logic [26:0] min_q     [NUM_OPS];
  logic [26:0] min_d     [NUM_OPS];

  logic [NEST_BITS-1:0] nest_q, nest_d;
  logic        span_first_q, span_first_d;
  logic [26:0] span_start_q, span_start_d;
  logic [26:0] span_end_q, span_end_d;
  logic [26:0] hdr_time_q, hdr_time_d;
  logic        hdr_vld_q, hdr_vld_d;
  logic [15:0] fcnt_q, fcnt_d;

  logic  out_vld_q, out_vld_d;
  item_t out_q, out_d;

  logic            out_free, op_last;
  logic [IdxW-1:0] op_idx, rd_idx;
  logic [32:0]     sum;
  logic [31:0]     tot_new, cnt_new;
  logic [26:0]     max_new, min_new;

  assign out_free = !out_vld_q || out_ready_i;
  assign op_last  = 5'(cmd_q.op) == 5'(NUM_OPS - 1);
  assign op_idx   = IdxW'(cmd_q.op);
  assign rd_idx   = (state_q == ST_REP) ? idx_q : op_idx;
  assign pop_o    = (state_q == ST_IDLE) && cmd_valid_i;

  assign sum     = 33'(tot_q[rd_idx]) + 33'(dur_q);
  assign tot_new = sum[32] ? '1 : sum[31:0];
  assign cnt_new = (cnt_q[rd_idx] == '1) ? cnt_q[rd_idx] : cnt_q[rd_idx] + 32'd1;
  assign max_new = (max_q[rd_idx] < dur_q) ? dur_q : max_q[rd_idx];
  assign min_new = (min_q[rd_idx] > dur_q) ? dur_q : min_q[rd_idx];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    dur_d        = dur_q;
    st_time_d    = st_time_q;
    st_vld_d     = st_vld_q;
    tot_d        = tot_q;
    cnt_d        = cnt_q;
    max_d        = max_q;
    min_d        = min_q;
    nest_d       = nest_q;
    span_first_d = span_first_q;
    span_start_d = span_start_q;
    span_end_d   = span_end_q;
    hdr_time_d   = hdr_time_q;
    hdr_vld_d    = hdr_vld_q;
    fcnt_d       = fcnt_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_d        = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_d      = '0;
          out_d.kind = KIND_STATUS;
          out_d.last = 1'b1;
          state_d    = ST_IDLE;
          if (cmd_q.kind == CMD_FLUSH) begin
            idx_d   = '0;
            state_d = ST_REP;
          end else if (cmd_q.kind == CMD_HEADER) begin
            if (hdr_vld_q && hdr_time_q != cmd_q.t) begin
              idx_d   = '0;
              state_d = ST_REP;
            end else begin
              hdr_time_d   = cmd_q.t;
              hdr_vld_d    = 1'b1;
              out_d.status = STS_HEADER;
              out_vld_d    = 1'b1;
            end
          end else begin
            if (span_first_q) begin
              span_start_d = cmd_q.t;
              span_first_d = 1'b0;
            end
            span_end_d = cmd_q.t;
            out_d.op   = cmd_q.op;
            out_vld_d  = 1'b1;
            case (cmd_q.kind)
              CMD_NOEE: begin
                out_d.status = STS_NOEE;
              end
              CMD_ENTER: begin
                out_d.status = STS_ENTER;
                if (op_last && nest_q != '0) begin
                  out_d.status = STS_NESTED;
                end else begin
                  st_time_d[op_idx] = cmd_q.t;
                  st_vld_d[op_idx]  = 1'b1;
                end
                if (op_last && nest_q != '1) begin
                  nest_d = nest_q + 1'b1;
                end
              end
              CMD_EXIT: begin
                if (op_last && nest_q == '0) begin
                  out_d.status = STS_UNDERRUN;
                end else if (op_last && nest_q != NEST_BITS'(1)) begin
                  nest_d       = nest_q - 1'b1;
                  out_d.status = STS_NESTED;
                end else begin
                  if (op_last) begin
                    nest_d = '0;
                  end
                  if (!st_vld_q[op_idx]) begin
                    out_d.status = STS_NO_ENTER;
                  end else begin
                    dur_d     = elapsed(st_time_q[op_idx], cmd_q.t);
                    out_vld_d = out_vld_q && !out_ready_i;
                    state_d   = ST_UPD;
                  end
                end
              end
              default: begin
                out_d.op     = '0;
                out_d.status = STS_TIMED;
              end
            endcase
          end
        end
      end
      ST_UPD: begin
        if (out_free) begin
          tot_d[op_idx]     = tot_new;
          cnt_d[op_idx]     = cnt_new;
          max_d[op_idx]     = max_new;
          min_d[op_idx]     = min_new;
          st_time_d[op_idx] = '0;
          st_vld_d[op_idx]  = 1'b0;
          out_d        = '0;
          out_d.kind   = KIND_STATUS;
          out_d.status = STS_EXIT;
          out_d.op     = cmd_q.op;
          out_d.dur    = dur_q;
          out_d.tot    = tot_new;
          out_d.cnt    = cnt_new;
          out_d.max    = max_new;
          out_d.min    = min_new;
          out_d.last   = 1'b1;
          out_vld_d    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_REP: begin
        if (out_free) begin
          out_d      = '0;
          out_d.kind = KIND_REPORT;
          out_d.op   = 3'(idx_q);
          out_d.tot  = tot_q[rd_idx];
          out_d.cnt  = cnt_q[rd_idx];
          out_d.max  = max_q[rd_idx];
          out_d.min  = min_q[rd_idx];
          out_d.rep  = fcnt_q;
          out_vld_d  = 1'b1;
          if (idx_q == IdxW'(NUM_OPS - 1)) begin
            state_d = ST_SPAN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_SPAN: begin
        if (out_free) begin
          out_d      = '0;
          out_d.kind = KIND_SPAN;
          out_d.dur  = span_first_q ? '0 : elapsed(span_start_q, span_end_q);
          out_d.rep  = fcnt_q;
          out_vld_d  = 1'b1;
          for (int i = 0; i < NUM_OPS; i++) begin
            st_time_d[i] = '0;
            st_vld_d[i]  = 1'b0;
            tot_d[i]     = '0;
            cnt_d[i]     = '0;
          end
          hdr_time_d   = '0;
          hdr_vld_d    = 1'b0;
          span_start_d = '0;
          span_end_d   = '0;
          span_first_d = 1'b1;
          nest_d       = '0;
          fcnt_d       = fcnt_q + 16'd1;
          state_d      = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_d        = '0;
          out_d.kind   = KIND_STATUS;
          out_d.status = STS_FLUSHED;
          out_d.last   = 1'b1;
          out_vld_d    = 1'b1;
          if (cmd_q.kind == CMD_HEADER) begin
            out_d.status = STS_HEADER;
            hdr_time_d   = cmd_q.t;
            hdr_vld_d    = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      out_vld_q    <= 1'b0;
      nest_q       <= '0;
      span_first_q <= 1'b1;
      span_start_q <= '0;
      span_end_q   <= '0;
      hdr_time_q   <= '0;
      hdr_vld_q    <= 1'b0;
      fcnt_q       <= '0;
      for (int i = 0; i < NUM_OPS; i++) begin
        st_time_q[i] <= '0;
        st_vld_q[i]  <= 1'b0;
        tot_q[i]     <= '0;
        cnt_q[i]     <= '0;
        max_q[i]     <= '0;
        min_q[i]     <= MinRst;
      end
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      out_vld_q    <= out_vld_d;
      nest_q       <= nest_d;
      span_first_q <= span_first_d;
      span_start_q <= span_start_d;
      span_end_q   <= span_end_d;
      hdr_time_q   <= hdr_time_d;
      hdr_vld_q    <= hdr_vld_d;
      fcnt_q       <= fcnt_d;
      st_time_q    <= st_time_d;
      st_vld_q     <= st_vld_d;
      tot_q        <= tot_d;
      cnt_q        <= cnt_d;
      max_q        <= max_d;
      min_q        <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    dur_q <= dur_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `EELP_ASSERT_IMP(a_upd_has_start, state_q == ST_UPD, st_vld_q[op_idx])
  `EELP_ASSERT_IMP(a_last_is_status, out_vld_q && out_q.last, out_q.kind == KIND_STATUS)

endmodule

>>> rtl/enter_exit_latency_profiler.sv
// ----------------------------------------------------------------------------
// enter_exit_latency_profiler
// per-operation enter/exit latency statistics with flushed reports
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                    | tuser
//  s_axis   | in  | op_id, hours, minutes, seconds, millis   | req_type, flush_req
//  m_axis   | out | status, op_index, duration_ms, total_ms, | item_kind
//           |     | event_count, max_ms, min_ms, report_num  | (tlast = last_item)
//
//  one event at a time in the back end: a status event is fetched and executed,
//  an exit that measures is fetched, executed and then updates the table
//  a flush or a header with a new time: fetch, execute, one report item per operation
//  read through the single read port of the table, span, final status
//  the front stage and a two-entry queue keep taking events meanwhile
//  reset is asynchronous active low, no clearing pass is needed
//  a stalled output holds its item and stalls the back end, and the input
//  once the queue and the front stage have filled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module enter_exit_latency_profiler #(
  parameter int unsigned NUM_OPS   = eelp_pkg::NumOpsDefault,
  parameter int unsigned NEST_BITS = eelp_pkg::NestBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // op_id[2:0], hours[7:3], minutes[13:8], seconds[19:14], millis[29:20], zero pad
  input  logic [31:0]  s_axis_tdata_i,
  // req_type[2:0], flush_req[3]
  input  logic [3:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[3:0], op_index[6:4], duration_ms[33:7], total_ms[65:34],
  // event_count[97:66], max_ms[124:98], min_ms[151:125], report_number[167:152]
  output logic [167:0] m_axis_tdata_o,
  // item_kind[1:0]
  output logic [1:0]   m_axis_tuser_o,
  output logic         m_axis_tlast_o
);
  import eelp_pkg::*;

  logic  push, full, pop, cmd_vld;
  cmd_t  front_cmd, back_cmd;
  item_t item;

  // front: decode and timestamp folding
  eelp_front #(
    .NUM_OPS (NUM_OPS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i[2:0]),
    .op_id_i     (s_axis_tdata_i[2:0]),
    .flush_req_i (s_axis_tuser_i[3]),
    .hours_i     (s_axis_tdata_i[7:3]),
    .minutes_i   (s_axis_tdata_i[13:8]),
    .seconds_i   (s_axis_tdata_i[19:14]),
    .millis_i    (s_axis_tdata_i[29:20]),
    .push_o      (push),
    .cmd_o       (front_cmd),
    .full_i      (full)
  );

  // short queue so front and back stall independently
  eelp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_vld),
    .data_o  (back_cmd)
  );

  // back: table update and report sequencing
  eelp_back #(
    .NUM_OPS   (NUM_OPS),
    .NEST_BITS (NEST_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_vld),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (item)
  );

  // output packing, status lowest and report number highest
  assign m_axis_tdata_o = {item.rep, item.min, item.max, item.cnt,
                           item.tot, item.dur, item.op, item.status};
  assign m_axis_tuser_o = item.kind;
  assign m_axis_tlast_o = item.last;

endmodule
